[sv/ipsbf_pkg.sv]
// Shared types and constants for the IPv4 source blocklist filter.
package ipsbf_pkg;

    localparam int STORE_ENTRIES = 1024;
    localparam int IDX_W = $clog2(STORE_ENTRIES);
    localparam int CNT_W = IDX_W + 1;

    localparam logic [15:0] TPID_CTAG  = 16'h8100;
    localparam logic [15:0] TPID_STAG  = 16'h88A8;
    localparam logic [15:0] ETYPE_IPV6 = 16'h86DD;

    localparam logic [1:0] KIND_BYTE   = 2'd0;
    localparam logic [1:0] KIND_ADD    = 2'd1;
    localparam logic [1:0] KIND_REMOVE = 2'd2;

    localparam logic [1:0] VERDICT_PASS  = 2'd0;
    localparam logic [1:0] VERDICT_DROP  = 2'd1;
    localparam logic [1:0] VERDICT_ABORT = 2'd2;

    localparam logic [1:0] STATUS_DONE     = 2'd0;
    localparam logic [1:0] STATUS_FULL     = 2'd1;
    localparam logic [1:0] STATUS_NOTFOUND = 2'd2;

    localparam logic ANSWER_VERDICT = 1'b0;
    localparam logic ANSWER_TABLE   = 1'b1;

    // back-end job codes
    localparam logic [1:0] OP_FIXED  = 2'd0;
    localparam logic [1:0] OP_LOOKUP = 2'd1;
    localparam logic [1:0] OP_ADD    = 2'd2;
    localparam logic [1:0] OP_REMOVE = 2'd3;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  packet_byte;
        logic        frame_end;
        logic [31:0] table_address;
    } t_in_item;

    typedef struct packed {
        logic        answer_kind;
        logic [1:0]  verdict;
        logic [1:0]  table_status;
        logic [31:0] source_address;
    } t_out_item;

    typedef struct packed {
        logic [1:0]  op;
        logic [1:0]  verdict;
        logic [31:0] addr;
    } t_job;

endpackage

[sv/ipsbf_front.sv]
// Frame byte parser: classifies items and emits back-end jobs.
module ipsbf_front
    import ipsbf_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_accept,
    input  t_in_item i_item,
    output logic     o_push,
    output t_job     o_job
);

    localparam logic [5:0] POS_LIMIT = 6'd38;

    logic [5:0]  r_pos, n_pos;
    logic [15:0] r_ek, n_ek;
    logic        r_tag, n_tag;
    logic [31:0] r_src, n_src;
    logic [5:0]  src_at;

    always_comb begin
        n_pos  = r_pos;
        n_ek   = r_ek;
        n_tag  = r_tag;
        n_src  = r_src;
        src_at = 6'd26;
        o_push = 1'b0;
        o_job  = '0;
        if (i_accept) begin
            if (i_item.kind == KIND_ADD || i_item.kind == KIND_REMOVE) begin
                o_push   = 1'b1;
                o_job.op = (i_item.kind == KIND_ADD) ? OP_ADD : OP_REMOVE;
                o_job.addr = i_item.table_address;
            end else if (i_item.kind == KIND_BYTE) begin
                if (r_pos < POS_LIMIT) begin
                    if (r_pos == 6'd12) begin
                        n_ek = {i_item.packet_byte, r_ek[7:0]};
                    end else if (r_pos == 6'd13) begin
                        n_ek  = {r_ek[15:8], i_item.packet_byte};
                        n_tag = (n_ek == TPID_CTAG) || (n_ek == TPID_STAG);
                    end else if (r_tag && r_pos == 6'd16) begin
                        n_ek = {i_item.packet_byte, r_ek[7:0]};
                    end else if (r_tag && r_pos == 6'd17) begin
                        n_ek = {r_ek[15:8], i_item.packet_byte};
                    end
                    src_at = n_tag ? 6'd30 : 6'd26;
                    if (r_pos >= src_at && r_pos < src_at + 6'd4) begin
                        n_src = {r_src[23:0], i_item.packet_byte};
                    end
                    n_pos = r_pos + 6'd1;
                end
                if (i_item.frame_end) begin
                    o_push = 1'b1;
                    o_job.op = OP_FIXED;
                    if (n_pos < 6'd14 || (n_tag && n_pos < 6'd18)) begin
                        o_job.verdict = VERDICT_ABORT;
                    end else if (n_ek == ETYPE_IPV6) begin
                        o_job.verdict = VERDICT_PASS;
                    end else if (n_pos < (n_tag ? 6'd38 : 6'd34)) begin
                        o_job.verdict = VERDICT_ABORT;
                    end else begin
                        o_job.op   = OP_LOOKUP;
                        o_job.addr = n_src;
                    end
                    n_pos = '0;
                    n_ek  = '0;
                    n_tag = 1'b0;
                    n_src = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_ek  <= '0;
            r_tag <= 1'b0;
            r_src <= '0;
        end else begin
            r_pos <= n_pos;
            r_ek  <= n_ek;
            r_tag <= n_tag;
            r_src <= n_src;
        end
    end

endmodule

[sv/ipsbf_queue.sv]
// Two-entry job queue between parser and table engine.
module ipsbf_queue
    import ipsbf_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output logic o_valid,
    output logic o_full,
    output t_job o_job
);

    t_job       r_slot [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_valid = (r_cnt != 2'd0);
    assign o_full  = (r_cnt == 2'd2);
    assign o_job   = r_slot[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

endmodule

[sv/ipsbf_back.sv]
// Table engine: clears, scans and updates the blocked-address store.
module ipsbf_back
    import ipsbf_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_q_valid,
    input  t_job      i_q_job,
    output logic      o_q_pop,
    output logic      o_clearing,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_item o_item
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_FIN   = 3'd3;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(STORE_ENTRIES - 1);

    logic [32:0]      r_mem [STORE_ENTRIES];
    logic [32:0]      r_rdata;
    logic [2:0]       r_state, n_state;
    logic [CNT_W-1:0] r_idx, n_idx;
    logic [IDX_W-1:0] r_ridx;
    logic             r_rvld;
    logic             r_hit, n_hit;
    logic [IDX_W-1:0] r_hit_idx, n_hit_idx;
    logic             r_free_ok, n_free_ok;
    logic [IDX_W-1:0] r_free_idx, n_free_idx;
    t_job             r_job, n_job;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_out_vld, n_out_vld;
    t_out_item        r_out, n_out;
    logic             w_we;
    logic [IDX_W-1:0] w_waddr;
    logic [32:0]      w_wdata;
    logic             out_free;

    assign o_clearing = (r_state == S_CLEAR);
    assign o_valid    = r_out_vld;
    assign o_item     = r_out;
    assign out_free   = !r_out_vld || !i_stall;

    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_hit      = r_hit;
        n_hit_idx  = r_hit_idx;
        n_free_ok  = r_free_ok;
        n_free_idx = r_free_idx;
        n_job      = r_job;
        n_count    = r_count;
        n_out_vld  = r_out_vld && i_stall;
        n_out      = r_out;
        w_we       = 1'b0;
        w_waddr    = r_idx[IDX_W-1:0];
        w_wdata    = '0;
        o_q_pop    = 1'b0;
        case (r_state)
            S_CLEAR: begin
                w_we  = 1'b1;
                n_idx = r_idx + 1'b1;
                if (r_idx[IDX_W-1:0] == LAST_IDX) begin
                    n_state = S_IDLE;
                    n_idx   = '0;
                end
            end
            S_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop   = 1'b1;
                    n_job     = i_q_job;
                    n_hit     = 1'b0;
                    n_free_ok = 1'b0;
                    n_idx     = '0;
                    n_state   = (i_q_job.op == OP_FIXED) ? S_FIN : S_SCAN;
                end
            end
            S_SCAN: begin
                if (!r_idx[IDX_W]) begin
                    n_idx = r_idx + 1'b1;
                end
                if (r_rvld) begin
                    if (r_rdata[32] && r_rdata[31:0] == r_job.addr) begin
                        n_hit     = 1'b1;
                        n_hit_idx = r_ridx;
                    end
                    if (!r_rdata[32] && !r_free_ok) begin
                        n_free_ok  = 1'b1;
                        n_free_idx = r_ridx;
                    end
                    if (r_ridx == LAST_IDX) begin
                        n_state = S_FIN;
                    end
                end
            end
            S_FIN: begin
                if (out_free) begin
                    n_out_vld = 1'b1;
                    n_out     = '0;
                    n_state   = S_IDLE;
                    case (r_job.op)
                        OP_FIXED: begin
                            n_out.answer_kind = ANSWER_VERDICT;
                            n_out.verdict     = r_job.verdict;
                        end
                        OP_LOOKUP: begin
                            n_out.answer_kind    = ANSWER_VERDICT;
                            n_out.verdict        = r_hit ? VERDICT_DROP : VERDICT_PASS;
                            n_out.source_address = r_job.addr;
                        end
                        OP_ADD: begin
                            n_out.answer_kind = ANSWER_TABLE;
                            if (!r_hit) begin
                                if (r_count >= CNT_W'(STORE_ENTRIES) || !r_free_ok) begin
                                    n_out.table_status = STATUS_FULL;
                                end else begin
                                    w_we    = 1'b1;
                                    w_waddr = r_free_idx;
                                    w_wdata = {1'b1, r_job.addr};
                                    n_count = r_count + 1'b1;
                                end
                            end
                        end
                        default: begin
                            n_out.answer_kind = ANSWER_TABLE;
                            if (r_hit) begin
                                w_we    = 1'b1;
                                w_waddr = r_hit_idx;
                                if (r_count != '0) begin
                                    n_count = r_count - 1'b1;
                                end
                            end else begin
                                n_out.table_status = STATUS_NOTFOUND;
                            end
                        end
                    endcase
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rdata <= r_mem[r_idx[IDX_W-1:0]];
        r_ridx  <= r_idx[IDX_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        r_hit_idx  <= n_hit_idx;
        r_free_idx <= n_free_idx;
        r_job      <= n_job;
        r_out      <= n_out;
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_idx     <= '0;
            r_rvld    <= 1'b0;
            r_hit     <= 1'b0;
            r_free_ok <= 1'b0;
            r_count   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_idx     <= n_idx;
            r_rvld    <= (r_state == S_SCAN) && !r_idx[IDX_W];
            r_hit     <= n_hit;
            r_free_ok <= n_free_ok;
            r_count   <= n_count;
            r_out_vld <= n_out_vld;
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(STORE_ENTRIES))
        else $error("entry count above store size");

    a_no_out_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !r_out_vld)
        else $error("result during clearing pass");

    a_write_ctx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (r_state == S_CLEAR || r_state == S_FIN))
        else $error("store write outside clear or finish");

    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |=> (r_state == S_SCAN || r_state == S_FIN))
        else $error("job popped without starting");

endmodule

[sv/ipv4_source_blocklist_filter_top.sv]
// Top level of the IPv4 source-address blocklist filter.
// Frame bytes are taken one per cycle unless the input stalls; a verdict for
// aborted/IPv6 frames needs no store scan, while a frame whose source address
// is looked up waits for the back end to scan the store, one entry a cycle.
// Add and remove items cost the same full scan of the store.
// Synchronous active-low reset; afterwards a clearing pass runs through the
// store, during which no item is taken.
module ipv4_source_blocklist_filter_top
    import ipsbf_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    logic accept;
    logic push;
    t_job push_job;
    logic q_valid, q_full, q_pop;
    t_job q_job;
    logic clearing;

    // Input stalls only while the job queue is full or the store is clearing;
    // frame bytes that raise no job still wait, keeping the rule simple.
    assign o_in_stall = q_full || clearing;
    assign accept     = i_in_valid && !o_in_stall;

    // Parser: tracks byte position, ethertype, tag and the source address.
    ipsbf_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (i_in_item),
        .o_push   (push),
        .o_job    (push_job)
    );

    // Short queue decouples parsing from the slow table scan.
    ipsbf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_job   (q_job)
    );

    // Table engine with registered result output.
    ipsbf_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .i_q_job    (q_job),
        .o_q_pop    (q_pop),
        .o_clearing (clearing),
        .o_valid    (o_out_valid),
        .i_stall    (i_out_stall),
        .o_item     (o_out_item)
    );

endmodule
